[rtl/sgr_pkg.sv]
// Shared constants, types and the 5x7 font table of the glyph rectangle renderer.
`default_nettype none

package sgr_pkg;

  // Screen size in pixels; the result coordinate widths (8 and 9 bits) are sized for it.
  localparam int unsigned SCREEN_WIDTH  = 240;
  localparam int unsigned SCREEN_HEIGHT = 320;

  localparam int unsigned GLYPH_COLS = 5;
  localparam int unsigned GLYPH_ROWS = 8;
  localparam int unsigned CELL_COLS  = 6;
  localparam int unsigned CELL_ROWS  = 8;

  // Candidate 0 is the background cell, candidate 1 + col*8 + row a glyph square.
  localparam int unsigned CAND_CNT  = 1 + GLYPH_COLS * GLYPH_ROWS;
  localparam int unsigned SEL_W     = $clog2(CAND_CNT);
  localparam int unsigned GLYPH_W   = GLYPH_COLS * GLYPH_ROWS;

  localparam int unsigned MAX_RECTS = 21;
  localparam int unsigned CNT_W     = $clog2(MAX_RECTS);

  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_UC_Z  = 8'h5A;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;
  localparam logic [7:0] CHAR_LC_Z  = 8'h7A;
  localparam logic [7:0] CHAR_QMARK = 8'h3F;
  localparam logic [7:0] CASE_FOLD  = 8'h20;

  typedef logic [CAND_CNT-1:0] cand_mask_t;
  typedef logic [SEL_W-1:0]    cand_sel_t;

  typedef struct packed {
    logic [7:0]  x;
    logic [8:0]  y;
    logic [7:0]  w;
    logic [8:0]  h;
    logic [15:0] color;
  } rect_t;

  // Font columns packed {col4, col3, col2, col1, col0}; bit 0 of each byte is the top row.
  function automatic logic [GLYPH_W-1:0] glyph_bits(input logic [5:0] idx);
    logic [GLYPH_W-1:0] g;
    unique case (idx)
      6'd0:  g = 40'h00_00_00_00_00;
      6'd1:  g = 40'h00_00_5F_00_00;
      6'd2:  g = 40'h00_07_00_07_00;
      6'd3:  g = 40'h14_7F_14_7F_14;
      6'd4:  g = 40'h12_2A_7F_2A_24;
      6'd5:  g = 40'h62_64_08_13_23;
      6'd6:  g = 40'h50_22_55_49_36;
      6'd7:  g = 40'h00_00_03_05_00;
      6'd8:  g = 40'h00_41_22_1C_00;
      6'd9:  g = 40'h00_1C_22_41_00;
      6'd10: g = 40'h14_08_3E_08_14;
      6'd11: g = 40'h08_08_3E_08_08;
      6'd12: g = 40'h00_00_30_50_00;
      6'd13: g = 40'h08_08_08_08_08;
      6'd14: g = 40'h00_00_60_60_00;
      6'd15: g = 40'h02_04_08_10_20;
      6'd16: g = 40'h3E_45_49_51_3E;
      6'd17: g = 40'h00_40_7F_42_00;
      6'd18: g = 40'h46_49_51_61_42;
      6'd19: g = 40'h31_4B_45_41_21;
      6'd20: g = 40'h10_7F_12_14_18;
      6'd21: g = 40'h39_45_45_45_27;
      6'd22: g = 40'h30_49_49_4A_3C;
      6'd23: g = 40'h03_05_09_71_01;
      6'd24: g = 40'h36_49_49_49_36;
      6'd25: g = 40'h1E_29_49_49_06;
      6'd26: g = 40'h00_00_36_36_00;
      6'd27: g = 40'h00_00_36_56_00;
      6'd28: g = 40'h00_41_22_14_08;
      6'd29: g = 40'h14_14_14_14_14;
      6'd30: g = 40'h08_14_22_41_00;
      6'd31: g = 40'h06_09_51_01_02;
      6'd32: g = 40'h3E_41_79_49_32;
      6'd33: g = 40'h7E_11_11_11_7E;
      6'd34: g = 40'h36_49_49_49_7F;
      6'd35: g = 40'h22_41_41_41_3E;
      6'd36: g = 40'h1C_22_41_41_7F;
      6'd37: g = 40'h41_49_49_49_7F;
      6'd38: g = 40'h01_09_09_09_7F;
      6'd39: g = 40'h7A_49_49_41_3E;
      6'd40: g = 40'h7F_08_08_08_7F;
      6'd41: g = 40'h00_41_7F_41_00;
      6'd42: g = 40'h01_3F_41_40_20;
      6'd43: g = 40'h41_22_14_08_7F;
      6'd44: g = 40'h40_40_40_40_7F;
      6'd45: g = 40'h7F_02_0C_02_7F;
      6'd46: g = 40'h7F_10_08_04_7F;
      6'd47: g = 40'h3E_41_41_41_3E;
      6'd48: g = 40'h06_09_09_09_7F;
      6'd49: g = 40'h5E_21_51_41_3E;
      6'd50: g = 40'h46_29_19_09_7F;
      6'd51: g = 40'h31_49_49_49_46;
      6'd52: g = 40'h01_01_7F_01_01;
      6'd53: g = 40'h3F_40_40_40_3F;
      6'd54: g = 40'h1F_20_40_20_1F;
      6'd55: g = 40'h3F_40_38_40_3F;
      6'd56: g = 40'h63_14_08_14_63;
      6'd57: g = 40'h07_08_70_08_07;
      6'd58: g = 40'h43_45_49_51_61;
      default: g = 40'h06_09_51_01_02;
    endcase
    return g;
  endfunction

endpackage

`default_nettype wire

[rtl/sgr_cell_decode.sv]
// Character decode: effective scale and the mask of visible rectangle candidates.
`default_nettype none

module sgr_cell_decode (
  input  wire logic [15:0]       pos_x,
  input  wire logic [15:0]       pos_y,
  input  wire logic [7:0]        char_code,
  input  wire logic [7:0]        scale,
  output sgr_pkg::cand_mask_t    cand_mask,
  output logic [7:0]             scale_eff
);
  import sgr_pkg::*;

  logic [7:0]         ch_fold;
  logic [7:0]         ch_sel;
  logic [5:0]         glyph_idx;
  logic [GLYPH_W-1:0] glyph;
  logic [15:0]        col_x [GLYPH_COLS];
  logic [15:0]        row_y [GLYPH_ROWS];
  logic [GLYPH_COLS-1:0] col_vis;
  logic [GLYPH_ROWS-1:0] row_vis;

  assign scale_eff = (scale == 8'd0) ? 8'd1 : scale;

  // Fold lowercase, then map anything outside space..Z to '?'.
  always_comb begin
    ch_fold = char_code;
    if (char_code >= CHAR_LC_A && char_code <= CHAR_LC_Z) begin
      ch_fold = char_code - CASE_FOLD;
    end
    ch_sel = ch_fold;
    if (ch_fold < CHAR_SPACE || ch_fold > CHAR_UC_Z) begin
      ch_sel = CHAR_QMARK;
    end
    glyph_idx = 6'(ch_sel - CHAR_SPACE);
  end

  assign glyph = glyph_bits(glyph_idx);

  // Square origins wrap at 16 bits; an origin off screen drops the square.
  always_comb begin
    for (int c = 0; c < GLYPH_COLS; c++) begin
      col_x[c]   = pos_x + {5'd0, 3'(c) * {3'd0, scale_eff}};
      col_vis[c] = col_x[c] < 16'(SCREEN_WIDTH);
    end
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      row_y[r]   = pos_y + {5'd0, 3'(r) * {3'd0, scale_eff}};
      row_vis[r] = row_y[r] < 16'(SCREEN_HEIGHT);
    end
  end

  always_comb begin
    cand_mask[0] = (pos_x < 16'(SCREEN_WIDTH)) && (pos_y < 16'(SCREEN_HEIGHT));
    for (int c = 0; c < GLYPH_COLS; c++) begin
      for (int r = 0; r < GLYPH_ROWS; r++) begin
        cand_mask[1 + c * GLYPH_ROWS + r] =
          glyph[c * GLYPH_ROWS + r] & col_vis[c] & row_vis[r];
      end
    end
  end

endmodule

`default_nettype wire

[rtl/sgr_rect_emit.sv]
// Rectangle pick: lowest pending candidate, its geometry and the edge clip.
`default_nettype none

module sgr_rect_emit (
  input  wire logic [15:0]        pos_x,
  input  wire logic [15:0]        pos_y,
  input  wire logic [7:0]         scale_eff,
  input  wire logic [15:0]        fg_color,
  input  wire logic [15:0]        bg_color,
  input  wire sgr_pkg::cand_mask_t cand_mask,
  output sgr_pkg::rect_t          rect,
  output sgr_pkg::cand_mask_t     rest_mask
);
  import sgr_pkg::*;

  cand_sel_t   sel;
  cand_sel_t   sq_idx;
  logic [2:0]  sq_col;
  logic [2:0]  sq_row;
  logic [15:0] org_x;
  logic [15:0] org_y;
  logic [10:0] size_w;
  logic [10:0] size_h;
  logic [15:0] color_sel;
  logic [16:0] end_x;
  logic [16:0] end_y;
  logic [15:0] clip_w;
  logic [15:0] clip_h;

  // Lowest set bit first keeps the background ahead and glyph squares column-major.
  always_comb begin
    sel = '0;
    for (int i = CAND_CNT - 1; i >= 0; i--) begin
      if (cand_mask[i]) begin
        sel = SEL_W'(i);
      end
    end
  end

  assign sq_idx = sel - SEL_W'(1);
  assign sq_col = sq_idx[5:3];
  assign sq_row = sq_idx[2:0];

  always_comb begin
    if (sel == '0) begin
      org_x     = pos_x;
      org_y     = pos_y;
      size_w    = 11'(CELL_COLS) * {3'd0, scale_eff};
      size_h    = 11'(CELL_ROWS) * {3'd0, scale_eff};
      color_sel = bg_color;
    end else begin
      org_x     = pos_x + {5'd0, sq_col * {3'd0, scale_eff}};
      org_y     = pos_y + {5'd0, sq_row * {3'd0, scale_eff}};
      size_w    = {3'd0, scale_eff};
      size_h    = {3'd0, scale_eff};
      color_sel = fg_color;
    end
  end

  // Origin is on screen here; cut the size to end at the right and bottom edges.
  always_comb begin
    end_x  = {1'b0, org_x} + {6'd0, size_w};
    end_y  = {1'b0, org_y} + {6'd0, size_h};
    clip_w = (end_x > 17'(SCREEN_WIDTH))  ? 16'(SCREEN_WIDTH)  - org_x : {5'd0, size_w};
    clip_h = (end_y > 17'(SCREEN_HEIGHT)) ? 16'(SCREEN_HEIGHT) - org_y : {5'd0, size_h};
    rect.x     = org_x[7:0];
    rect.y     = org_y[8:0];
    rect.w     = clip_w[7:0];
    rect.h     = clip_h[8:0];
    rect.color = color_sel;
  end

  assign rest_mask = cand_mask & ~(cand_mask_t'(1) << sel);

endmodule

`default_nettype wire

[rtl/scaled_glyph_rect_renderer_unit.sv]
// Top level of the scaled glyph renderer: input register, rectangle walker, result register.
//
// Usage:
//   One input transaction carries a character cell (position, code, colors, scale).
//   The block answers with a run of fill-rectangle result transactions: the clipped
//   background cell first, then one scale-by-scale square per set font pixel, column
//   by column, top to bottom. Squares whose origin is off screen are dropped and the
//   run is capped at 21 rectangles; the final one has out_last_rect high. A character
//   with nothing on screen yields no result transaction at all.
// Path: an accepted character waits in the input register, then loads into the walker,
//   and each of its rectangles then leaves through the result register.
// Throughput: one rectangle per cycle unless out_ready stalls the output; a character
//   gives N rectangles, N being its visible rectangle count (at most 21). The walker
//   takes the next character in the cycle its last rectangle leaves, so characters
//   stream without gaps; the input register holds one character in waiting.
// Stall: when out_ready is low the result register holds, the walker holds, and
//   in_ready drops once the input register is full. No transaction is lost.
// Reset: synchronous active-low rst_n empties all three stages; no memory to clear.
`default_nettype none

module scaled_glyph_rect_renderer_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [15:0] in_pos_x,
  input  wire logic [15:0] in_pos_y,
  input  wire logic [7:0]  in_char_code,
  input  wire logic [15:0] in_fg_color,
  input  wire logic [15:0] in_bg_color,
  input  wire logic [7:0]  in_scale,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_rect_x,
  output logic [8:0]       out_rect_y,
  output logic [7:0]       out_rect_w,
  output logic [8:0]       out_rect_h,
  output logic [15:0]      out_rect_color,
  output logic             out_last_rect
);
  import sgr_pkg::*;

  // Input register
  logic        s1_vld_r;
  logic [15:0] s1_px_r;
  logic [15:0] s1_py_r;
  logic [7:0]  s1_char_r;
  logic [15:0] s1_fg_r;
  logic [15:0] s1_bg_r;
  logic [7:0]  s1_scale_r;

  // Rectangle walker
  logic             wk_vld_r;
  logic [15:0]      wk_px_r;
  logic [15:0]      wk_py_r;
  logic [7:0]       wk_scale_r;
  logic [15:0]      wk_fg_r;
  logic [15:0]      wk_bg_r;
  cand_mask_t       wk_mask_r;
  logic [CNT_W-1:0] wk_cnt_r;

  // Result register
  logic  out_vld_r;
  rect_t out_rect_r;
  logic  out_last_r;

  cand_mask_t dec_mask;
  logic [7:0] dec_scale;
  rect_t      emit_rect;
  cand_mask_t emit_rest;
  logic       out_free;
  logic       emit_fire;
  logic       emit_last;
  logic       walk_free;
  logic       wk_load;
  logic       in_fire;

  sgr_cell_decode u_decode (
    .pos_x     (s1_px_r),
    .pos_y     (s1_py_r),
    .char_code (s1_char_r),
    .scale     (s1_scale_r),
    .cand_mask (dec_mask),
    .scale_eff (dec_scale)
  );

  sgr_rect_emit u_emit (
    .pos_x     (wk_px_r),
    .pos_y     (wk_py_r),
    .scale_eff (wk_scale_r),
    .fg_color  (wk_fg_r),
    .bg_color  (wk_bg_r),
    .cand_mask (wk_mask_r),
    .rect      (emit_rect),
    .rest_mask (emit_rest)
  );

  // Handshake chain: result register frees the walker, the walker frees the input register.
  assign out_free  = !out_vld_r || out_ready;
  assign emit_fire = wk_vld_r && out_free;
  assign emit_last = (emit_rest == '0) || (wk_cnt_r == CNT_W'(MAX_RECTS - 1));
  assign walk_free = !wk_vld_r || (emit_fire && emit_last);
  assign wk_load   = s1_vld_r && walk_free;
  assign in_ready  = !s1_vld_r || wk_load;
  assign in_fire   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_fire) begin
      s1_vld_r <= 1'b1;
    end else if (wk_load) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_px_r    <= in_pos_x;
      s1_py_r    <= in_pos_y;
      s1_char_r  <= in_char_code;
      s1_fg_r    <= in_fg_color;
      s1_bg_r    <= in_bg_color;
      s1_scale_r <= in_scale;
    end
  end

  // Load a new character (drop it if nothing is visible), else advance past the emitted one.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wk_vld_r <= 1'b0;
      wk_cnt_r <= '0;
    end else if (wk_load) begin
      wk_vld_r <= (dec_mask != '0);
      wk_cnt_r <= '0;
    end else if (emit_fire) begin
      if (emit_last) begin
        wk_vld_r <= 1'b0;
      end
      wk_cnt_r <= wk_cnt_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (wk_load) begin
      wk_px_r    <= s1_px_r;
      wk_py_r    <= s1_py_r;
      wk_scale_r <= dec_scale;
      wk_fg_r    <= s1_fg_r;
      wk_bg_r    <= s1_bg_r;
      wk_mask_r  <= dec_mask;
    end else if (emit_fire) begin
      wk_mask_r  <= emit_rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (emit_fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit_fire) begin
      out_rect_r <= emit_rect;
      out_last_r <= emit_last;
    end
  end

  assign out_valid      = out_vld_r;
  assign out_rect_x     = out_rect_r.x;
  assign out_rect_y     = out_rect_r.y;
  assign out_rect_w     = out_rect_r.w;
  assign out_rect_h     = out_rect_r.h;
  assign out_rect_color = out_rect_r.color;
  assign out_last_rect  = out_last_r;

`ifndef SYNTHESIS
  // An active walker always has a rectangle pending.
  a_walker_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    wk_vld_r |-> (wk_mask_r != '0))
    else $error("walker active with empty candidate mask");

  // Run cap: the walker never counts past the last allowed rectangle.
  a_cnt_cap: assert property (@(posedge clk) disable iff (!rst_n)
    wk_vld_r |-> (wk_cnt_r <= CNT_W'(MAX_RECTS - 1)))
    else $error("rectangle count beyond cap");

  // Every presented rectangle sits on screen with a nonzero size.
  a_rect_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_rect_r.x < 8'(SCREEN_WIDTH)) && (out_rect_r.y < 9'(SCREEN_HEIGHT))
                  && (out_rect_r.w != '0) && (out_rect_r.h != '0))
    else $error("rectangle off screen or empty");

  // A final rectangle taken frees the walker unless a new character loads the same cycle.
  a_last_frees: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && emit_last && !wk_load) |=> !wk_vld_r)
    else $error("walker still active after last rectangle");
`endif

endmodule

`default_nettype wire

[test/tb.sv]
// Self-checking testbench for the scaled glyph rectangle renderer.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned SCR_W         = sgr_pkg::SCREEN_WIDTH;
  localparam int unsigned SCR_H         = sgr_pkg::SCREEN_HEIGHT;
  localparam int unsigned RECT_CAP      = sgr_pkg::MAX_RECTS;
  localparam int          RANDOM_CELLS  = 250;
  localparam int          IDLE_LIMIT    = 2000;  // cycles with no transaction on either side
  localparam int          DRAIN_CYCLES  = 10;
  localparam int          LONG_STALL_AT = 120;   // accepted characters before the long stall
  localparam int          LONG_STALL    = 300;

  // One character cell as offered on the input channel.
  typedef struct packed {
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [7:0]  char_code;
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [7:0]  scale;
  } glyph_cell_t;

  // One clipped fill rectangle as seen on the result channel.
  typedef struct packed {
    logic [7:0]  x;
    logic [8:0]  y;
    logic [7:0]  w;
    logic [8:0]  h;
    logic [15:0] color;
    logic        last;
  } fill_rect_t;

  typedef enum logic [1:0] {
    READY_ALWAYS,
    READY_COIN,
    READY_SPARSE,
    READY_MOSTLY
  } ready_mode_t;

  logic        clk            = 1'b0;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_ready;
  logic [15:0] in_pos_x       = '0;
  logic [15:0] in_pos_y       = '0;
  logic [7:0]  in_char_code   = '0;
  logic [15:0] in_fg_color    = '0;
  logic [15:0] in_bg_color    = '0;
  logic [7:0]  in_scale       = '0;
  logic        out_valid;
  logic        out_ready      = 1'b0;
  logic [7:0]  out_rect_x;
  logic [8:0]  out_rect_y;
  logic [7:0]  out_rect_w;
  logic [8:0]  out_rect_h;
  logic [15:0] out_rect_color;
  logic        out_last_rect;

  glyph_cell_t cell_queue[$];       // characters still to be offered
  fill_rect_t  predicted_rects[$];  // rectangles the block still owes us

  logic        in_taken        = 1'b0;  // input transaction at the last rising edge
  int          cells_accepted  = 0;
  int          mismatches      = 0;
  int          idle_cycles     = 0;
  int          burst_left      = 25;
  int          gap_left        = 0;
  int          stall_left      = 0;
  logic        long_stall_done = 1'b0;
  logic [31:0] rx_cycle        = '0;
  ready_mode_t ready_mode      = READY_ALWAYS;

  scaled_glyph_rect_renderer_unit dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_pos_x       (in_pos_x),
    .in_pos_y       (in_pos_y),
    .in_char_code   (in_char_code),
    .in_fg_color    (in_fg_color),
    .in_bg_color    (in_bg_color),
    .in_scale       (in_scale),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_rect_x     (out_rect_x),
    .out_rect_y     (out_rect_y),
    .out_rect_w     (out_rect_w),
    .out_rect_h     (out_rect_h),
    .out_rect_color (out_rect_color),
    .out_last_rect  (out_last_rect)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // 5x7 font, one byte per column, col0 in the top byte, bit 0 is the top row.
  function automatic logic [7:0] font_column(input int unsigned idx, input int unsigned col);
    logic [39:0] g;
    case (idx)
      0:  g = 40'h00_00_00_00_00;
      1:  g = 40'h00_00_5F_00_00;
      2:  g = 40'h00_07_00_07_00;
      3:  g = 40'h14_7F_14_7F_14;
      4:  g = 40'h24_2A_7F_2A_12;
      5:  g = 40'h23_13_08_64_62;
      6:  g = 40'h36_49_55_22_50;
      7:  g = 40'h00_05_03_00_00;
      8:  g = 40'h00_1C_22_41_00;
      9:  g = 40'h00_41_22_1C_00;
      10: g = 40'h14_08_3E_08_14;
      11: g = 40'h08_08_3E_08_08;
      12: g = 40'h00_50_30_00_00;
      13: g = 40'h08_08_08_08_08;
      14: g = 40'h00_60_60_00_00;
      15: g = 40'h20_10_08_04_02;
      16: g = 40'h3E_51_49_45_3E;
      17: g = 40'h00_42_7F_40_00;
      18: g = 40'h42_61_51_49_46;
      19: g = 40'h21_41_45_4B_31;
      20: g = 40'h18_14_12_7F_10;
      21: g = 40'h27_45_45_45_39;
      22: g = 40'h3C_4A_49_49_30;
      23: g = 40'h01_71_09_05_03;
      24: g = 40'h36_49_49_49_36;
      25: g = 40'h06_49_49_29_1E;
      26: g = 40'h00_36_36_00_00;
      27: g = 40'h00_56_36_00_00;
      28: g = 40'h08_14_22_41_00;
      29: g = 40'h14_14_14_14_14;
      30: g = 40'h00_41_22_14_08;
      31: g = 40'h02_01_51_09_06;
      32: g = 40'h32_49_79_41_3E;
      33: g = 40'h7E_11_11_11_7E;
      34: g = 40'h7F_49_49_49_36;
      35: g = 40'h3E_41_41_41_22;
      36: g = 40'h7F_41_41_22_1C;
      37: g = 40'h7F_49_49_49_41;
      38: g = 40'h7F_09_09_09_01;
      39: g = 40'h3E_41_49_49_7A;
      40: g = 40'h7F_08_08_08_7F;
      41: g = 40'h00_41_7F_41_00;
      42: g = 40'h20_40_41_3F_01;
      43: g = 40'h7F_08_14_22_41;
      44: g = 40'h7F_40_40_40_40;
      45: g = 40'h7F_02_0C_02_7F;
      46: g = 40'h7F_04_08_10_7F;
      47: g = 40'h3E_41_41_41_3E;
      48: g = 40'h7F_09_09_09_06;
      49: g = 40'h3E_41_51_21_5E;
      50: g = 40'h7F_09_19_29_46;
      51: g = 40'h46_49_49_49_31;
      52: g = 40'h01_01_7F_01_01;
      53: g = 40'h3F_40_40_40_3F;
      54: g = 40'h1F_20_40_20_1F;
      55: g = 40'h3F_40_38_40_3F;
      56: g = 40'h63_14_08_14_63;
      57: g = 40'h07_08_70_08_07;
      58: g = 40'h61_51_49_45_43;
      default: g = 40'h02_01_51_09_06;
    endcase
    return g[39 - 8*col -: 8];
  endfunction

  // Drop a rectangle whose origin is off screen, else cut it at the right and bottom edge.
  function automatic bit clip_to_screen(input int unsigned x, input int unsigned y,
                                        input int unsigned w, input int unsigned h,
                                        input logic [15:0] color, output fill_rect_t r);
    int unsigned cw;
    int unsigned chgt;
    r = '0;
    if (x >= SCR_W || y >= SCR_H) return 1'b0;
    cw   = (x + w > SCR_W) ? SCR_W - x : w;
    chgt = (y + h > SCR_H) ? SCR_H - y : h;
    r.x     = x[7:0];
    r.y     = y[8:0];
    r.w     = cw[7:0];
    r.h     = chgt[8:0];
    r.color = color;
    r.last  = 1'b0;
    return 1'b1;
  endfunction

  // Work out the rectangles one character produces and queue them in order.
  function automatic void render_glyph_rects(input glyph_cell_t c);
    fill_rect_t  run[RECT_CAP];
    fill_rect_t  r;
    int unsigned s;
    int unsigned code;
    int unsigned idx;
    int unsigned n;
    logic [7:0]  bits;
    n = 0;
    s = (c.scale == 8'd0) ? 32'd1 : 32'(c.scale);
    code = 32'(c.char_code);
    if (code >= 32'h61 && code <= 32'h7A) code = code - 32'd32;  // fold lowercase
    if (code < 32'h20 || code > 32'h5A) code = 32'h3F;          // unsupported renders as '?'
    idx = code - 32'h20;

    if (clip_to_screen(32'(c.pos_x), 32'(c.pos_y), 6 * s, 8 * s, c.bg_color, r)) begin
      run[n] = r;
      n++;
    end
    for (int col = 0; col < 5; col++) begin
      bits = font_column(idx, col);
      for (int row = 0; row < 8; row++) begin
        if (bits[row] && n < RECT_CAP &&
            clip_to_screen((32'(c.pos_x) + col * s) & 32'hFFFF,
                           (32'(c.pos_y) + row * s) & 32'hFFFF,
                           s, s, c.fg_color, r)) begin
          run[n] = r;
          n++;
        end
      end
    end
    for (int i = 0; i < n; i++) begin
      r = run[i];
      r.last = (i == n - 1);
      predicted_rects.push_back(r);
    end
  endfunction

  function automatic glyph_cell_t make_cell(input logic [15:0] x, input logic [15:0] y,
                                            input logic [7:0] code, input logic [15:0] fg,
                                            input logic [15:0] bg, input logic [7:0] sc);
    glyph_cell_t c;
    c.pos_x     = x;
    c.pos_y     = y;
    c.char_code = code;
    c.fg_color  = fg;
    c.bg_color  = bg;
    c.scale     = sc;
    return c;
  endfunction

  // Mostly on-screen cells with small scales; some wrap, hug the edge or are fully random.
  function automatic glyph_cell_t random_cell();
    glyph_cell_t c;
    case ($urandom_range(0, 9))
      7: begin
        c.pos_x = 16'($urandom_range(65500, 65535));
        c.pos_y = ($urandom_range(0, 1) != 0) ? 16'($urandom_range(65500, 65535))
                                               : 16'($urandom_range(0, 330));
      end
      8: begin
        c.pos_x = 16'($urandom_range(0, 65535));
        c.pos_y = 16'($urandom_range(0, 65535));
      end
      9: begin
        c.pos_x = 16'($urandom_range(225, 239));
        c.pos_y = 16'($urandom_range(305, 319));
      end
      default: begin
        c.pos_x = 16'($urandom_range(0, 250));
        c.pos_y = 16'($urandom_range(0, 330));
      end
    endcase
    case ($urandom_range(0, 9))
      6, 7:    c.char_code = 8'($urandom_range(8'h61, 8'h7A));
      8, 9:    c.char_code = 8'($urandom_range(0, 255));
      default: c.char_code = 8'($urandom_range(8'h20, 8'h5A));
    endcase
    case ($urandom_range(0, 9))
      6, 7:    c.scale = 8'($urandom_range(4, 12));
      8:       c.scale = 8'd0;
      9:       c.scale = 8'($urandom_range(0, 255));
      default: c.scale = 8'($urandom_range(0, 3));
    endcase
    c.fg_color = 16'($urandom_range(0, 65535));
    c.bg_color = 16'($urandom_range(0, 65535));
    return c;
  endfunction

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endtask

  // Driver: present the next character at the falling edge, in bursts with gaps between.
  always @(negedge clk) begin : drive_cells
    glyph_cell_t pending;
    if (rst_n) begin
      if (in_valid && !in_taken) begin
        // hold the offered transaction until it is accepted
      end else if (gap_left > 0) begin
        in_valid <= 1'b0;
        gap_left <= gap_left - 1;
      end else if (cell_queue.size() > 0) begin
        pending = cell_queue.pop_front();
        in_valid     <= 1'b1;
        in_pos_x     <= pending.pos_x;
        in_pos_y     <= pending.pos_y;
        in_char_code <= pending.char_code;
        in_fg_color  <= pending.fg_color;
        in_bg_color  <= pending.bg_color;
        in_scale     <= pending.scale;
        if (burst_left <= 1) begin
          // pick the next burst; a zero gap keeps the stream running back to back
          burst_left <= $urandom_range(1, 40);
          gap_left   <= ($urandom_range(0, 4) < 2) ? 0 : $urandom_range(1, 30);
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: change ready at the falling edge; one long stall lets the block back up.
  always @(negedge clk) begin : drive_ready
    rx_cycle <= rx_cycle + 1;
    if (rx_cycle[5:0] == 6'd0) ready_mode <= ready_mode_t'($urandom_range(0, 3));
    if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!long_stall_done && cells_accepted >= LONG_STALL_AT) begin
      out_ready       <= 1'b0;
      stall_left      <= LONG_STALL - 1;
      long_stall_done <= 1'b1;
    end else begin
      case (ready_mode)
        READY_ALWAYS: out_ready <= 1'b1;
        READY_COIN:   out_ready <= 1'($urandom_range(0, 1));
        READY_SPARSE: out_ready <= (rx_cycle[1:0] == 2'd0);
        default:      out_ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  // Monitor: check each result transaction against the oldest prediction, then
  // predict for a character accepted at this same edge.
  always @(posedge clk) begin : watch_channels
    fill_rect_t want;
    in_taken <= rst_n && in_valid && in_ready;
    if (rst_n && out_valid && out_ready) begin
      if (predicted_rects.size() == 0) begin
        $display("%0t ns: unexpected rectangle, expected none, got x=%0d y=%0d w=%0d h=%0d",
                 $time, out_rect_x, out_rect_y, out_rect_w, out_rect_h);
        mismatches++;
      end else begin
        want = predicted_rects.pop_front();
        check_field("rect_x", 16'(want.x), 16'(out_rect_x));
        check_field("rect_y", 16'(want.y), 16'(out_rect_y));
        check_field("rect_w", 16'(want.w), 16'(out_rect_w));
        check_field("rect_h", 16'(want.h), 16'(out_rect_h));
        check_field("rect_color", want.color, out_rect_color);
        check_field("last_rect", 16'(want.last), 16'(out_last_rect));
      end
    end
    if (rst_n && in_valid && in_ready) begin
      render_glyph_rects({in_pos_x, in_pos_y, in_char_code, in_fg_color, in_bg_color,
                          in_scale});
      cells_accepted <= cells_accepted + 1;
    end
  end

  // Watchdog: end the run if no transaction moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("simulation failed");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    // Directed characters: case folding, unsupported codes, scale extremes,
    // wrapping origins, edge clipping, fully dropped cells, color extremes.
    cell_queue.push_back(make_cell(16'd0, 16'd0, "A", 16'hFFFF, 16'h0000, 8'd1));
    cell_queue.push_back(make_cell(16'd10, 16'd20, "B", 16'h0000, 16'hFFFF, 8'd0));
    cell_queue.push_back(make_cell(16'd30, 16'd40, "a", 16'hF800, 16'h07E0, 8'd1));
    cell_queue.push_back(make_cell(16'd50, 16'd60, "z", 16'h001F, 16'hFFE0, 8'd2));
    cell_queue.push_back(make_cell(16'd70, 16'd80, 8'h00, 16'h1234, 16'h5678, 8'd1));
    cell_queue.push_back(make_cell(16'd80, 16'd90, 8'h1F, 16'h1111, 16'h2222, 8'd1));
    cell_queue.push_back(make_cell(16'd90, 16'd100, 8'h5B, 16'h3333, 16'h4444, 8'd1));
    cell_queue.push_back(make_cell(16'd100, 16'd110, 8'h60, 16'h5555, 16'h6666, 8'd1));
    cell_queue.push_back(make_cell(16'd110, 16'd120, 8'h7B, 16'h7777, 16'h8888, 8'd1));
    cell_queue.push_back(make_cell(16'd120, 16'd130, 8'h7F, 16'h9999, 16'hAAAA, 8'd1));
    cell_queue.push_back(make_cell(16'd130, 16'd140, 8'h80, 16'hBBBB, 16'hCCCC, 8'd1));
    cell_queue.push_back(make_cell(16'd140, 16'd150, 8'hFF, 16'hDDDD, 16'hEEEE, 8'd1));
    cell_queue.push_back(make_cell(16'd150, 16'd160, " ", 16'hFFFF, 16'h0000, 8'd1));
    cell_queue.push_back(make_cell(16'd160, 16'd170, "Z", 16'h0000, 16'hFFFF, 8'd1));
    cell_queue.push_back(make_cell(16'd4, 16'd4, "#", 16'hA5A5, 16'h5A5A, 8'd3));
    cell_queue.push_back(make_cell(16'd0, 16'd0, "@", 16'hFFFF, 16'h0000, 8'd255));
    cell_queue.push_back(make_cell(16'hFFFF, 16'hFFFF, "M", 16'hFFFF, 16'hFFFF, 8'd1));
    cell_queue.push_back(make_cell(16'hFFFE, 16'd5, "W", 16'h0F0F, 16'hF0F0, 8'd1));
    cell_queue.push_back(make_cell(16'd5, 16'hFFFC, "H", 16'h00FF, 16'hFF00, 8'd2));
    cell_queue.push_back(make_cell(16'd236, 16'd316, "8", 16'h1357, 16'h2468, 8'd2));
    cell_queue.push_back(make_cell(16'd239, 16'd319, "0", 16'h8642, 16'h7531, 8'd3));
    cell_queue.push_back(make_cell(16'd240, 16'd10, "X", 16'h0001, 16'h0002, 8'd1));
    cell_queue.push_back(make_cell(16'd10, 16'd320, "Y", 16'h0004, 16'h0008, 8'd1));
    cell_queue.push_back(make_cell(16'd200, 16'd250, "Q", 16'hFFFF, 16'h0000, 8'd128));
    for (int i = 0; i < RANDOM_CELLS; i++) cell_queue.push_back(random_cell());

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // wait for every character to be taken, then for every rectangle to arrive
    while (cell_queue.size() != 0 || in_valid) @(posedge clk);
    while (predicted_rects.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
